// File: hdl/lsegt_pkg.sv
package lsegt_pkg;

  localparam int LSG_LEAVES = 1024;
  localparam int ACT_W      = 2;
  localparam int POS_W      = 11;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 64;
  localparam int IN_W       = 56;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_ASSIGN = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  // One tree node: settled sum and its pending tags.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] add;
    logic [VAL_W-1:0] aval;
    logic             aflag;
  } node_t;

endpackage

// File: hdl/lazy_segment_tree_add_assign_sum.sv
// Lazy segment tree: range add, range assign and range sum over positions
// 1..length_in_use, sums modulo 2^64.
// Input channel in_*: one request per beat (action, range, value). Output
// channel out_*: one 64-bit sum per query beat; add, assign and unused action
// give no beat. Config channel cfg_*: taken only while idle, writes
// length_in_use (0 reads as 1, above LEAVES as LEAVES) and clears the tree.
// Each request walks the tree one node at a time through the node RAM and
// one shared multiplier: each node is read, settled and written back, and an
// inner node also pushes its tags into both children; on the way back each
// split node sums its children (written back unless querying), and a query
// then loads the output register. A wide range visits roughly
// 4*log2(LEAVES) nodes; in_tready is low while the walk runs.
// After reset and after each config write the node RAM is cleared, one entry
// per cycle, all 4*LEAVES entries, with in_tready low. A finished sum sits in the
// output register; a new request is taken while it waits, and a following
// query holds at its end until out_tready drains the earlier beat.
module lazy_segment_tree_add_assign_sum
  import lsegt_pkg::*;
#(
  parameter int LEAVES = LSG_LEAVES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // action, range_low, range_high, operand_value
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [SUM_W-1:0] out_tdata,  // range_sum
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data    // length_in_use
);

  localparam int NODES = 4 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int STK   = $clog2(LEAVES) + 1;
  localparam int SPW   = $clog2(STK + 1);
  localparam int TW    = $clog2(STK);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_NRD   = 12'b000000000100,
    S_M1    = 12'b000000001000,
    S_M2    = 12'b000000010000,
    S_M3    = 12'b000000100000,
    S_NWR   = 12'b000001000000,
    S_CRD   = 12'b000010000000,
    S_CLAT  = 12'b000100000000,
    S_CHK   = 12'b001000000000,
    S_RET   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [POS_W-1:0] len_in_use_r;
  logic [AW-1:0]    clr_r;
  act_t             act_r;
  logic [POS_W-1:0] a_r, b_r;
  logic [VAL_W-1:0] v_r;
  logic [AW-1:0]    cur_node_r;
  logic [POS_W-1:0] cur_lo_r, cur_hi_r;
  logic             cidx_r;
  logic [SUM_W-1:0] p_a_r, p_b_r, p_v_r, settled_r, ret_r;
  logic             ct_flag_r;
  logic [VAL_W-1:0] ct_val_r;
  logic [SUM_W-1:0] ct_add_r;
  logic [SPW-1:0]   sp_r;
  logic [SUM_W-1:0] out_data_r;
  logic             out_valid_r;

  logic [AW-1:0]    stk_node_r [STK];
  logic [POS_W-1:0] stk_lo_r   [STK];
  logic [POS_W-1:0] stk_hi_r   [STK];
  logic             stk_ph_r   [STK];
  logic [SUM_W-1:0] stk_acc_r  [STK];

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  node_t            mem_wdata, rd;

  logic [POS_W-1:0] len, cur_mid, top_mid;
  logic             covered, outside;
  logic [SUM_W-1:0] mul_a, mul_p, node_new, child_sum_total;
  logic [AW-1:0]    child;
  logic [TW-1:0]    top, push_i;
  logic             in_acc, cfg_acc, out_take;
  logic [POS_W-1:0] cfg_len;
  node_t            child_upd;

  lsegt_node_ram #(.DEPTH(NODES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  // a config beat wins over a request offered in the same cycle
  assign in_tready  = (state_r == S_IDLE) & ~cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_acc    = cfg_valid & cfg_ready;
  assign out_take   = out_valid_r & out_tready;

  assign len     = cur_hi_r - cur_lo_r + POS_W'(1);
  assign cur_mid = cur_lo_r + ((cur_hi_r - cur_lo_r) >> 1);
  assign top     = TW'(sp_r - SPW'(1));
  assign push_i  = sp_r[TW-1:0];
  assign top_mid = stk_lo_r[top] + ((stk_hi_r[top] - stk_lo_r[top]) >> 1);
  assign child   = {cur_node_r[AW-2:0], cidx_r};
  assign covered = (a_r <= cur_lo_r) && (cur_hi_r <= b_r);
  assign outside = (a_r > cur_hi_r) || (b_r < cur_lo_r);
  assign child_sum_total = stk_acc_r[top] + ret_r;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_len = POS_W'(1);
    end else if (32'(cfg_data) > LEAVES) begin
      cfg_len = POS_W'(LEAVES);
    end else begin
      cfg_len = cfg_data;
    end
  end

  // Shared multiplier: tag or operand times node length.
  always_comb begin
    case (state_r)
      S_M1:    mul_a = {{(SUM_W-VAL_W){1'b0}}, rd.aval};
      S_M2:    mul_a = rd.add;
      default: mul_a = {{(SUM_W-VAL_W){1'b0}}, v_r};
    endcase
  end
  assign mul_p = mul_a * SUM_W'(len);

  always_comb begin
    if (covered && act_r == ACT_ADD) begin
      node_new = settled_r + p_v_r;
    end else if (covered && act_r == ACT_ASSIGN) begin
      node_new = p_v_r;
    end else begin
      node_new = settled_r;
    end
  end

  // Parent tag lands on top of the child's own: an assignment overrides.
  always_comb begin
    child_upd = rd;
    if (ct_flag_r) begin
      child_upd.aflag = 1'b1;
      child_upd.aval  = ct_val_r;
      child_upd.add   = ct_add_r;
    end else begin
      child_upd.add   = rd.add + ct_add_r;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_node_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cur_node_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      S_NRD: begin
        mem_re = 1'b1;
      end
      S_NWR: begin
        mem_we        = 1'b1;
        mem_wdata.sum = node_new;
      end
      S_CRD: begin
        mem_re    = 1'b1;
        mem_raddr = child;
      end
      S_CLAT: begin
        mem_we    = 1'b1;
        mem_waddr = child;
        mem_wdata = child_upd;
      end
      S_RET: begin
        if (sp_r != '0 && stk_ph_r[top] && act_r != ACT_QUERY) begin
          mem_we        = 1'b1;
          mem_waddr     = stk_node_r[top];
          mem_wdata.sum = child_sum_total;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && act_t'(in_tdata[ACT_W-1:0]) != ACT_NONE) begin
          state_nxt = S_NRD;
        end
      end
      S_CLEAR: begin
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_NRD:  state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_NWR;
      S_NWR:  state_nxt = (cur_lo_r != cur_hi_r) ? S_CRD : S_CHK;
      S_CRD:  state_nxt = S_CLAT;
      S_CLAT: state_nxt = cidx_r ? S_CHK : S_CRD;
      S_CHK:  state_nxt = (outside || covered) ? S_RET : S_NRD;
      S_RET: begin
        if (sp_r == '0) begin
          state_nxt = (act_r == ACT_QUERY) ? S_DONE : S_IDLE;
        end else if (!stk_ph_r[top]) begin
          state_nxt = S_NRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_acc) begin
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      len_in_use_r <= POS_W'(LEAVES);
      clr_r        <= '0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        len_in_use_r <= cfg_len;
        clr_r        <= '0;
      end else if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (in_acc) begin
        sp_r <= '0;
      end else if (state_r == S_CHK && !(outside || covered)) begin
        sp_r <= sp_r + SPW'(1);
      end else if (state_r == S_RET && sp_r != '0 && stk_ph_r[top]) begin
        sp_r <= sp_r - SPW'(1);
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        act_r      <= act_t'(in_tdata[1:0]);
        a_r        <= in_tdata[12:2];
        b_r        <= in_tdata[23:13];
        v_r        <= in_tdata[55:24];
        cur_node_r <= AW'(1);
        cur_lo_r   <= POS_W'(1);
        cur_hi_r   <= len_in_use_r;
      end
      S_M1: p_a_r <= mul_p;
      S_M2: p_b_r <= mul_p;
      S_M3: begin
        p_v_r     <= mul_p;
        settled_r <= (rd.aflag ? p_a_r : rd.sum) + p_b_r;
        if (covered && act_r == ACT_ASSIGN) begin
          ct_flag_r <= 1'b1;
          ct_val_r  <= v_r;
          ct_add_r  <= '0;
        end else begin
          ct_flag_r <= rd.aflag;
          ct_val_r  <= rd.aval;
          ct_add_r  <= (covered && act_r == ACT_ADD) ?
                       rd.add + {{(SUM_W-VAL_W){1'b0}}, v_r} : rd.add;
        end
      end
      S_NWR: begin
        ret_r  <= (act_r == ACT_QUERY && outside) ? '0 : node_new;
        cidx_r <= 1'b0;
      end
      S_CLAT: cidx_r <= 1'b1;
      S_CHK: begin
        if (!(outside || covered)) begin
          // descend left, keep this node as the parent frame
          stk_node_r[push_i] <= cur_node_r;
          stk_lo_r[push_i]   <= cur_lo_r;
          stk_hi_r[push_i]   <= cur_hi_r;
          stk_ph_r[push_i]   <= 1'b0;
          cur_node_r         <= {cur_node_r[AW-2:0], 1'b0};
          cur_hi_r           <= cur_mid;
        end
      end
      S_RET: begin
        if (sp_r != '0) begin
          if (!stk_ph_r[top]) begin
            stk_ph_r[top]  <= 1'b1;
            stk_acc_r[top] <= ret_r;
            cur_node_r     <= {stk_node_r[top][AW-2:0], 1'b1};
            cur_lo_r       <= top_mid + POS_W'(1);
            cur_hi_r       <= stk_hi_r[top];
          end else begin
            ret_r <= child_sum_total;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= ret_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/lsegt_node_ram.sv
module lsegt_node_ram
  import lsegt_pkg::*;
#(
  parameter int DEPTH = 4 * LSG_LEAVES,
  parameter int AW    = $clog2(4 * LSG_LEAVES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  node_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output node_t         rdata
);

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
